// File: rtl/pcmdm_pkg.sv
`default_nettype none

package pcmdm_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 16;

   localparam int SAMPLE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_WIDTH_MODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT     = CSR_INDEX_W'(1);

   localparam logic MODE_8BIT  = 1'b0;
   localparam logic MODE_16BIT = 1'b1;

   localparam logic             MODE_RESET  = MODE_16BIT;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: rtl/pcm_downmix_to_mono_byte_unit.sv
// Multichannel PCM to 8-bit mono downmixer. Interleaved samples arrive one
// per request; channel_count samples form a frame, whose sum is divided by the
// channel count (truncating toward zero) and returned as one unsigned byte with
// offset 128. A sample inside a frame is taken without a stall; the last sample of
// a frame stalls requests while the restoring divider retires one quotient bit
// per cycle, and while the result waits for the result register to be taken. Any
// write to a known register drops the partial frame; a partial trailing frame never
// produces a result.
`default_nettype none

module pcm_downmix_to_mono_byte_unit #(
   parameter int MAX_CHANNELS = pcmdm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [pcmdm_pkg::SAMPLE_W-1:0]   req_sample_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [pcmdm_pkg::BYTE_W-1:0]          rsp_mono_byte,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pcmdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pcmdm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pcmdm_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   state_type state_ff, state_in;

   logic               mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]   chan_n;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;

   logic               req_accept;
   logic               csr_write;
   logic               csr_known;
   logic               frame_end;
   logic signed [SUM_W-1:0] sum_total;
   logic signed [SUM_W-1:0] avg;
   logic [BYTE_W-1:0]  avg_byte;

   div_ctrl_type   div_ctrl;
   div_status_type div_status;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_known  = (csr_index == REG_SAMPLE_WIDTH_MODE) ||
                       (csr_index == REG_CHANNEL_COUNT);
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SAMPLE_WIDTH_MODE: mode_in  = csr_data[0];
            REG_CHANNEL_COUNT:     count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         chan_n = CNT_W'(1);
      end else if (int'(count_ff) > MAX_CHANNELS) begin
         chan_n = CNT_W'(MAX_CHANNELS);
      end else begin
         chan_n = CNT_W'(count_ff);
      end
   end

   pcmdm_accum #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .clear      (csr_write && csr_known),
      .mode       (mode_ff),
      .chan_n     (chan_n),
      .sample_word(req_sample_word),
      .frame_end  (frame_end),
      .sum_total  (sum_total)
   );

   pcmdm_divider #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .dividend(sum_total),
      .divisor (chan_n),
      .status  (div_status),
      .quotient(avg)
   );

   // adding 128 (or 32768) flips the top bit of the kept byte
   assign avg_byte = (mode_ff == MODE_16BIT) ? {~avg[15], avg[14:8]}
                                             : {~avg[7], avg[6:0]};

   always_comb begin
      state_in       = state_ff;
      div_ctrl.start = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && frame_end) begin
               div_ctrl.start = 1'b1;
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = avg_byte;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mono_byte = rsp_byte_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> req_stall)
      else $error("divider busy while requests are taken");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DELIVER))
      else $error("result appeared without a finished frame");
`endif

endmodule

`default_nettype wire

// File: rtl/pcmdm_accum.sv
`default_nettype none

module pcmdm_accum #(
   parameter int SUM_W = 20,
   parameter int CNT_W = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          clear,
   input  wire logic                          mode,
   input  wire logic [CNT_W-1:0]              chan_n,
   input  wire logic [pcmdm_pkg::SAMPLE_W-1:0] sample_word,
   output logic                               frame_end,
   output logic signed [SUM_W-1:0]            sum_total
);
   import pcmdm_pkg::*;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        index_ff, index_in;
   logic signed [SUM_W-1:0] sample_value;
   logic [CNT_W-1:0]        index_plus;

   // 8-bit mode: low byte minus 128 is the byte with its top bit flipped
   always_comb begin
      if (mode == MODE_16BIT) begin
         sample_value = SUM_W'(signed'(sample_word));
      end else begin
         sample_value = SUM_W'(signed'({~sample_word[7], sample_word[6:0]}));
      end
   end

   assign index_plus = index_ff + CNT_W'(1);
   assign frame_end  = index_plus >= chan_n;
   assign sum_total  = sum_ff + sample_value;

   always_comb begin
      sum_in   = sum_ff;
      index_in = index_ff;
      if (clear) begin
         sum_in   = '0;
         index_in = '0;
      end else if (accept) begin
         if (frame_end) begin
            sum_in   = '0;
            index_in = '0;
         end else begin
            sum_in   = sum_total;
            index_in = index_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         index_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pcmdm_divider.sv
`default_nettype none

module pcmdm_divider #(
   parameter int SUM_W = 20,
   parameter int CNT_W = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pcmdm_pkg::div_ctrl_type   ctrl,
   input  wire logic signed [SUM_W-1:0]   dividend,
   input  wire logic [CNT_W-1:0]          divisor,
   output pcmdm_pkg::div_status_type      status,
   output logic signed [SUM_W-1:0]        quotient
);
   import pcmdm_pkg::*;

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    trial;
   logic              fits;
   logic [SUM_W-1:0]  magnitude;

   assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

   // one restoring step per cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = magnitude;
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         iter_in = ITER_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign quotient    = neg_ff ? SUM_W'(-signed'(quo_ff)) : signed'(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire
